### hw/rtl/afr_pkg.sv
// Shared constants, types and the rounding helper for the axes frame rotation block.
// No dependencies; every other file of the block imports this package.
package afr_pkg;

  localparam int MATRIX_FRAC_BITS = 16;
  localparam int DATA_WIDTH       = 32;

  localparam int AXIS_W = 16;                    // configured axis components
  localparam int MW     = MATRIX_FRAC_BITS + 2;  // signed Q1.F matrix coefficient
  localparam int VW     = 2 * AXIS_W + 1;        // cross product component
  localparam int WW     = VW - 1;                // magnitude of a vector component
  localparam int SQW    = 2 * WW;                // sum of squares
  localparam int RW     = WW;                    // integer square root
  localparam int QB     = MATRIX_FRAC_BITS + 3;  // quotient bits of the divider
  localparam int QCW    = $clog2(QB);
  localparam int KW     = $clog2(SQW / 2);
  localparam int NUMW   = WW + MATRIX_FRAC_BITS + 1;
  localparam int REMW   = RW + 1;

  localparam int PRODA_W = DATA_WIDTH + MW;
  localparam int PW      = DATA_WIDTH + MW + 2 - MATRIX_FRAC_BITS;
  localparam int PRODC_W = MW + PW;
  localparam int ACC_W   = PRODC_W + 2;

  localparam logic signed [MW-1:0] COEF_ONE = MW'(1) << MATRIX_FRAC_BITS;
  localparam logic signed [ACC_W-1:0] SAT_HI = (ACC_W'(1) << (DATA_WIDTH - 1)) - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - ACC_W'(1);

  localparam logic [1:0] OP_FWD = 2'd0;
  localparam logic [1:0] OP_INV = 2'd1;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_COLINEAR = 2'd1;
  localparam logic [1:0] ST_SAT      = 2'd2;

  localparam logic [1:0] ORD_ABC = 2'd0;
  localparam logic [1:0] ORD_CAB = 2'd1;

  localparam logic [2:0] CFG_FIRST_X  = 3'd0;
  localparam logic [2:0] CFG_FIRST_Y  = 3'd1;
  localparam logic [2:0] CFG_FIRST_Z  = 3'd2;
  localparam logic [2:0] CFG_SECOND_X = 3'd3;
  localparam logic [2:0] CFG_SECOND_Y = 3'd4;
  localparam logic [2:0] CFG_SECOND_Z = 3'd5;
  localparam logic [2:0] CFG_ORDER    = 3'd6;
  localparam logic [2:0] CFG_LIMIT    = 3'd7;

  typedef logic signed [MW-1:0] coef_t;
  typedef logic signed [VW-1:0] vcomp_t;

  typedef struct packed {
    logic valid;
    logic colinear;
  } frame_stat_t;

  typedef enum logic [2:0] {
    NS_IDLE, NS_SHIFT, NS_SQ, NS_SQRT, NS_DIV_INIT, NS_DIV_RUN, NS_DIV_STORE, NS_DONE
  } norm_state_e;

  typedef enum logic [3:0] {
    FS_IDLE, FS_CROSS, FS_MAG, FS_CHECK, FS_NORM_A, FS_WAIT_A, FS_NORM_C, FS_WAIT_C, FS_ROWS
  } frame_state_e;

  // Drops MATRIX_FRAC_BITS fraction bits, rounding half away from zero.
  function automatic logic signed [ACC_W-1:0] rnd_frac(input logic signed [ACC_W-1:0] x);
    logic [ACC_W-1:0] mag;
    mag = x[ACC_W-1] ? ACC_W'(-x) : ACC_W'(x);
    mag = (mag + (ACC_W'(1) << (MATRIX_FRAC_BITS - 1))) >> MATRIX_FRAC_BITS;
    return x[ACC_W-1] ? $signed(-mag) : $signed(mag);
  endfunction

endpackage

### hw/rtl/afr_norm.sv
// Vector normalizer: shift up, sum of squares, bit-pair square root, restoring divide.
// Uses afr_pkg; one vector at a time, started by a pulse, finished with a done pulse.
module afr_norm
  import afr_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   start_i,
  input  vcomp_t vec_i [3],
  output logic   done_o,
  output coef_t  q_o [3]
);

  norm_state_e state_q, state_d;
  logic [WW-1:0]   w_q [3];
  logic            neg_q [3];
  logic [SQW-1:0]  x_q, r_q;
  logic [KW-1:0]   k_q;
  logic [1:0]      j_q;
  logic [REMW-1:0] rem_q;
  logic [QB-1:0]   lo_q, quo_q;
  logic [QCW-1:0]  cnt_q;
  coef_t           q_q [3];

  logic [SQW-1:0]  bitv, trial;
  logic            sq_ge, top_set, div_ge;
  logic [NUMW-1:0] num;
  logic [REMW-1:0] rem2;
  logic [QB-1:0]   cap;

  always_comb begin
    bitv    = SQW'(1) << {k_q, 1'b0};
    trial   = r_q + bitv;
    sq_ge   = x_q >= trial;
    top_set = |(w_q[0][WW-1:WW-2] | w_q[1][WW-1:WW-2] | w_q[2][WW-1:WW-2]);
    num     = (NUMW'(w_q[j_q]) << MATRIX_FRAC_BITS) + NUMW'(r_q[RW-1:1]);
    rem2    = {rem_q[REMW-2:0], lo_q[QB-1]};
    div_ge  = rem2 >= {1'b0, r_q[RW-1:0]};
    cap     = (quo_q > QB'(COEF_ONE)) ? QB'(COEF_ONE) : quo_q;
  end

  always_comb begin
    state_d = state_q;
    done_o  = 1'b0;
    unique case (state_q)
      NS_IDLE:      if (start_i) state_d = NS_SHIFT;
      NS_SHIFT:     if (top_set) state_d = NS_SQ;
      NS_SQ:        state_d = NS_SQRT;
      NS_SQRT:      if (k_q == '0) state_d = NS_DIV_INIT;
      NS_DIV_INIT:  state_d = NS_DIV_RUN;
      NS_DIV_RUN:   if (cnt_q == '0) state_d = NS_DIV_STORE;
      NS_DIV_STORE: state_d = (j_q == 2'd2) ? NS_DONE : NS_DIV_INIT;
      NS_DONE: begin
        done_o  = 1'b1;
        state_d = NS_IDLE;
      end
      default:      state_d = NS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= NS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      NS_IDLE: begin
        for (int i = 0; i < 3; i++) begin
          neg_q[i] <= vec_i[i][VW-1];
          w_q[i]   <= vec_i[i][VW-1] ? WW'(-vec_i[i]) : WW'(vec_i[i]);
        end
      end
      NS_SHIFT: begin
        if (!top_set) begin
          for (int i = 0; i < 3; i++) w_q[i] <= w_q[i] << 1;
        end
      end
      NS_SQ: begin
        x_q <= SQW'(w_q[0] * w_q[0]) + SQW'(w_q[1] * w_q[1]) + SQW'(w_q[2] * w_q[2]);
        r_q <= '0;
        k_q <= KW'(SQW / 2 - 1);
        j_q <= 2'd0;
      end
      NS_SQRT: begin
        if (sq_ge) begin
          x_q <= x_q - trial;
          r_q <= (r_q >> 1) + bitv;
        end else begin
          r_q <= r_q >> 1;
        end
        k_q <= k_q - KW'(1);
      end
      NS_DIV_INIT: begin
        rem_q <= REMW'(num >> QB);
        lo_q  <= num[QB-1:0];
        quo_q <= '0;
        cnt_q <= QCW'(QB - 1);
      end
      NS_DIV_RUN: begin
        rem_q <= div_ge ? rem2 - {1'b0, r_q[RW-1:0]} : rem2;
        lo_q  <= lo_q << 1;
        quo_q <= {quo_q[QB-2:0], div_ge};
        cnt_q <= cnt_q - QCW'(1);
      end
      NS_DIV_STORE: begin
        q_q[j_q] <= neg_q[j_q] ? -MW'(cap) : MW'(cap);
        j_q      <= j_q + 2'd1;
      end
      default: ;
    endcase
  end

  assign q_o = q_q;

endmodule

### hw/rtl/afr_frame.sv
// Configuration registers and the frame builder sequencer that fills the rotation matrix.
// Uses afr_pkg and afr_norm; the matrix is rebuilt on the first item after a register write.
module afr_frame
  import afr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        build_i,
  output coef_t       m_o [9],
  output frame_stat_t stat_o
);

  frame_state_e state_q, state_d;
  logic signed [AXIS_W-1:0] a1_q [3];
  logic signed [AXIS_W-1:0] a2_q [3];
  logic [1:0]  order_q;
  logic [15:0] limit_q;

  vcomp_t       u_q [3];
  logic [31:0]  asq_q, limsq_q;
  logic [SQW-1:0] usq_q;
  logic [32:0]  thr_q;
  coef_t        a_q [3];
  coef_t        c_q [3];
  coef_t        m_q [9];
  logic         valid_q, col_q;

  logic         norm_start, norm_done;
  vcomp_t       norm_vec [3];
  coef_t        norm_q [3];
  logic [63:0]  lim;
  coef_t        b [3];
  logic signed [ACC_W-1:0] bsum [3];

  afr_norm u_norm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (norm_start),
    .vec_i   (norm_vec),
    .done_o  (norm_done),
    .q_o     (norm_q)
  );

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      norm_vec[i] = (state_q == FS_NORM_A) ? VW'(a1_q[i]) : u_q[i];
    end
    lim = 64'(limsq_q) * 64'(asq_q);
    bsum[0] = ACC_W'(c_q[1] * a_q[2]) - ACC_W'(c_q[2] * a_q[1]);
    bsum[1] = ACC_W'(c_q[2] * a_q[0]) - ACC_W'(c_q[0] * a_q[2]);
    bsum[2] = ACC_W'(c_q[0] * a_q[1]) - ACC_W'(c_q[1] * a_q[0]);
    for (int i = 0; i < 3; i++) b[i] = MW'(rnd_frac(bsum[i]));
  end

  always_comb begin
    state_d    = state_q;
    norm_start = 1'b0;
    unique case (state_q)
      FS_IDLE:   if (build_i && !valid_q) state_d = FS_CROSS;
      FS_CROSS:  state_d = FS_MAG;
      FS_MAG:    state_d = FS_CHECK;
      FS_CHECK:  state_d = (usq_q == '0 || usq_q < SQW'(thr_q)) ? FS_IDLE : FS_NORM_A;
      FS_NORM_A: begin
        norm_start = 1'b1;
        state_d    = FS_WAIT_A;
      end
      FS_WAIT_A: if (norm_done) state_d = FS_NORM_C;
      FS_NORM_C: begin
        norm_start = 1'b1;
        state_d    = FS_WAIT_C;
      end
      FS_WAIT_C: if (norm_done) state_d = FS_ROWS;
      FS_ROWS:   state_d = FS_IDLE;
      default:   state_d = FS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FS_IDLE;
      a1_q    <= '{16'sd0, 16'sd0, 16'sd1};
      a2_q    <= '{16'sd1, 16'sd0, 16'sd0};
      order_q <= 2'd2;
      limit_q <= 16'd16;
      valid_q <= 1'b0;
      col_q   <= 1'b0;
      for (int i = 0; i < 9; i++) m_q[i] <= (i % 4 == 0) ? COEF_ONE : '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        valid_q <= 1'b0;
        unique case (cfg_index_i)
          CFG_FIRST_X:  a1_q[0] <= cfg_data_i;
          CFG_FIRST_Y:  a1_q[1] <= cfg_data_i;
          CFG_FIRST_Z:  a1_q[2] <= cfg_data_i;
          CFG_SECOND_X: a2_q[0] <= cfg_data_i;
          CFG_SECOND_Y: a2_q[1] <= cfg_data_i;
          CFG_SECOND_Z: a2_q[2] <= cfg_data_i;
          CFG_ORDER:    order_q <= cfg_data_i[1:0];
          CFG_LIMIT:    limit_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (state_q == FS_CHECK && state_d == FS_IDLE) begin
        // Axes too close to colinear: fall back to the identity frame.
        valid_q <= 1'b1;
        col_q   <= 1'b1;
        for (int i = 0; i < 9; i++) m_q[i] <= (i % 4 == 0) ? COEF_ONE : '0;
      end
      if (state_q == FS_ROWS) begin
        valid_q <= 1'b1;
        col_q   <= 1'b0;
        for (int j = 0; j < 3; j++) begin
          if (order_q == ORD_ABC) begin
            m_q[j] <= a_q[j]; m_q[3+j] <= b[j]; m_q[6+j] <= c_q[j];
          end else if (order_q == ORD_CAB) begin
            m_q[j] <= c_q[j]; m_q[3+j] <= a_q[j]; m_q[6+j] <= b[j];
          end else begin
            m_q[j] <= b[j]; m_q[3+j] <= c_q[j]; m_q[6+j] <= a_q[j];
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == FS_CROSS) begin
      u_q[0]  <= VW'(a1_q[1] * a2_q[2]) - VW'(a1_q[2] * a2_q[1]);
      u_q[1]  <= VW'(a1_q[2] * a2_q[0]) - VW'(a1_q[0] * a2_q[2]);
      u_q[2]  <= VW'(a1_q[0] * a2_q[1]) - VW'(a1_q[1] * a2_q[0]);
      asq_q   <= 32'(a1_q[0] * a1_q[0]) + 32'(a1_q[1] * a1_q[1]) + 32'(a1_q[2] * a1_q[2]);
      limsq_q <= 32'(limit_q) * 32'(limit_q);
    end
    if (state_q == FS_MAG) begin
      usq_q <= SQW'(u_q[0] * u_q[0]) + SQW'(u_q[1] * u_q[1]) + SQW'(u_q[2] * u_q[2]);
      thr_q <= 33'(lim[63:32]) + 33'(|lim[31:0]);
    end
    if (state_q == FS_WAIT_A && norm_done) a_q <= norm_q;
    if (state_q == FS_WAIT_C && norm_done) c_q <= norm_q;
  end

  assign m_o             = m_q;
  assign stat_o.valid    = valid_q;
  assign stat_o.colinear = col_q;

endmodule

### hw/rtl/afr_pipe.sv
// Four-stage multiply pipeline: products, first rounded sums, products, rounded saturated sums.
// Uses afr_pkg; the last stage is the output register, and every stage moves together.
module afr_pipe
  import afr_pkg::*;
(
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         acc_i,
  input  logic [1:0]                   op_i,
  input  logic signed [DATA_WIDTH-1:0] t_i [9],
  input  coef_t                        m_i [9],
  input  logic                         col_i,
  input  logic                         out_ready_i,
  output logic                         adv_o,
  output logic                         out_valid_o,
  output logic signed [DATA_WIDTH-1:0] res_o [9],
  output logic [1:0]                   status_o
);

  logic vA_q, vB_q, vC_q, vD_q;
  logic [1:0] opA_q, opB_q, opC_q;
  logic colA_q, colB_q, colC_q;
  logic signed [PRODA_W-1:0] pa_q [27];
  logic signed [PW-1:0]      pb_q [9];
  logic signed [PRODC_W-1:0] pc_q [27];
  logic signed [DATA_WIDTH-1:0] res_q [9];
  logic [1:0] status_q;

  logic signed [DATA_WIDTH-1:0] xa [27];
  coef_t                        ya [27];
  coef_t                        mm [9];
  logic signed [ACC_W-1:0]      sum_b [9];
  logic signed [ACC_W-1:0]      val_d [9];
  logic signed [DATA_WIDTH-1:0] sat_d [9];
  logic                         hit_d [9];
  logic signed [DATA_WIDTH-1:0] res_d [9];
  logic                         sat_any;

  assign adv_o = !vD_q || out_ready_i;

  always_comb begin
    // Stage A operands: the tensor uses T*M, the inverse puts M*v in column 0, and the
    // forward operation passes v through unchanged in column 0.
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        for (int i = 0; i < 3; i++) begin
          xa[r*9+c*3+i] = '0;
          ya[r*9+c*3+i] = '0;
          if (op_i[1]) begin
            xa[r*9+c*3+i] = t_i[r*3+i];
            ya[r*9+c*3+i] = m_i[i*3+c];
          end else if (c == 0 && op_i == OP_INV) begin
            xa[r*9+c*3+i] = t_i[i];
            ya[r*9+c*3+i] = m_i[r*3+i];
          end else if (c == 0 && i == r) begin
            xa[r*9+c*3+i] = t_i[r];
            ya[r*9+c*3+i] = COEF_ONE;
          end
        end
      end
    end
    for (int n = 0; n < 9; n++) begin
      sum_b[n] = ACC_W'(pa_q[n*3]) + ACC_W'(pa_q[n*3+1]) + ACC_W'(pa_q[n*3+2]);
    end
    // The inverse result is already complete, so stage C multiplies it by identity.
    for (int n = 0; n < 9; n++) begin
      mm[n] = (opB_q == OP_INV) ? ((n % 4 == 0) ? COEF_ONE : '0) : m_i[n];
    end
    for (int n = 0; n < 9; n++) begin
      val_d[n] = rnd_frac(ACC_W'(pc_q[n*3]) + ACC_W'(pc_q[n*3+1]) + ACC_W'(pc_q[n*3+2]));
      hit_d[n] = (val_d[n] > SAT_HI) || (val_d[n] < SAT_LO);
      sat_d[n] = (val_d[n] > SAT_HI) ? DATA_WIDTH'(SAT_HI) :
                 (val_d[n] < SAT_LO) ? DATA_WIDTH'(SAT_LO) : DATA_WIDTH'(val_d[n]);
    end
    sat_any = 1'b0;
    for (int n = 0; n < 9; n++) begin
      res_d[n] = '0;
      if (opC_q[1]) begin
        res_d[n] = sat_d[n];
        sat_any  = sat_any | hit_d[n];
      end else if (n < 3) begin
        res_d[n] = sat_d[n*3];
        sat_any  = sat_any | hit_d[n*3];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vA_q <= 1'b0;
      vB_q <= 1'b0;
      vC_q <= 1'b0;
      vD_q <= 1'b0;
    end else if (adv_o) begin
      vA_q <= acc_i;
      vB_q <= vA_q;
      vC_q <= vB_q;
      vD_q <= vC_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_o) begin
      opA_q  <= op_i;
      colA_q <= col_i;
      for (int n = 0; n < 27; n++) pa_q[n] <= PRODA_W'(xa[n] * ya[n]);
      opB_q  <= opA_q;
      colB_q <= colA_q;
      for (int n = 0; n < 9; n++) pb_q[n] <= PW'(rnd_frac(sum_b[n]));
      opC_q  <= opB_q;
      colC_q <= colB_q;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          for (int k = 0; k < 3; k++) begin
            pc_q[(i*3+j)*3+k] <= PRODC_W'(mm[k*3+i] * pb_q[k*3+j]);
          end
        end
      end
      res_q    <= res_d;
      status_q <= colC_q ? ST_COLINEAR : (sat_any ? ST_SAT : ST_OK);
    end
  end

  assign out_valid_o = vD_q;
  assign res_o       = res_q;
  assign status_o    = status_q;

endmodule

### hw/rtl/axes_frame_rotation.sv
// Top level of the axes frame rotation block: ports, frame builder and multiply pipeline.
// Uses afr_pkg, afr_frame (with afr_norm) and afr_pipe.
//
//  Port group    Direction  Handshake                 Contents
//  in_*          input      in_valid_i / in_ready_o    op_i, in_0_i .. in_8_i
//  out_*         output     out_valid_o / out_ready_i  out_0_o .. out_8_o, status_o
//  cfg_*         input      cfg_we_i, no wait          cfg_index_i, cfg_data_i
//
// One item enters per cycle while the output is not stalled and the frame is valid;
// its result passes stages A, B, C and the output register D before it can leave.
// The first item after reset or after a register write waits while the frame is
// rebuilt: cross product and magnitude check, then shift, square root and division
// for each of the two normalized axes in turn, on the shared normalizer.
// A stalled output holds every stage in place; nothing is dropped or repeated.
module axes_frame_rotation
  import afr_pkg::*;
(
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [2:0]                   cfg_index_i,
  input  logic [15:0]                  cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [1:0]                   op_i,
  input  logic signed [DATA_WIDTH-1:0] in_0_i,
  input  logic signed [DATA_WIDTH-1:0] in_1_i,
  input  logic signed [DATA_WIDTH-1:0] in_2_i,
  input  logic signed [DATA_WIDTH-1:0] in_3_i,
  input  logic signed [DATA_WIDTH-1:0] in_4_i,
  input  logic signed [DATA_WIDTH-1:0] in_5_i,
  input  logic signed [DATA_WIDTH-1:0] in_6_i,
  input  logic signed [DATA_WIDTH-1:0] in_7_i,
  input  logic signed [DATA_WIDTH-1:0] in_8_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [DATA_WIDTH-1:0] out_0_o,
  output logic signed [DATA_WIDTH-1:0] out_1_o,
  output logic signed [DATA_WIDTH-1:0] out_2_o,
  output logic signed [DATA_WIDTH-1:0] out_3_o,
  output logic signed [DATA_WIDTH-1:0] out_4_o,
  output logic signed [DATA_WIDTH-1:0] out_5_o,
  output logic signed [DATA_WIDTH-1:0] out_6_o,
  output logic signed [DATA_WIDTH-1:0] out_7_o,
  output logic signed [DATA_WIDTH-1:0] out_8_o,
  output logic [1:0]                   status_o
);

  coef_t       m [9];
  frame_stat_t stat;
  logic        adv;
  logic signed [DATA_WIDTH-1:0] t [9];
  logic signed [DATA_WIDTH-1:0] res [9];

  assign t = '{in_0_i, in_1_i, in_2_i, in_3_i, in_4_i, in_5_i, in_6_i, in_7_i, in_8_i};

  // Items are held off until the frame matches the current registers.
  assign in_ready_o = adv && stat.valid;

  afr_frame u_frame (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .build_i     (in_valid_i),
    .m_o         (m),
    .stat_o      (stat)
  );

  afr_pipe u_pipe (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .acc_i       (in_valid_i && in_ready_o),
    .op_i        (op_i),
    .t_i         (t),
    .m_i         (m),
    .col_i       (stat.colinear),
    .out_ready_i (out_ready_i),
    .adv_o       (adv),
    .out_valid_o (out_valid_o),
    .res_o       (res),
    .status_o    (status_o)
  );

  assign out_0_o = res[0];
  assign out_1_o = res[1];
  assign out_2_o = res[2];
  assign out_3_o = res[3];
  assign out_4_o = res[4];
  assign out_5_o = res[5];
  assign out_6_o = res[6];
  assign out_7_o = res[7];
  assign out_8_o = res[8];

endmodule

### bench/tb.sv
// Self-checking bench for axes_frame_rotation: a frame predictor with scoreboard,
// random sender bursts, a stalling receiver and register phases. Depends on afr_pkg.
module tb;
  import afr_pkg::*;

  localparam logic [1:0] ORD_BCA   = 2'd2;
  localparam logic [1:0] ORD_SPARE = 2'd3;
  localparam int CYCLE_LIMIT = 400000;

  typedef logic [8:0][DATA_WIDTH-1:0] nine_t;

  class frame_scoreboard;
    longint mat[9];
    bit built, colin;
    logic [15:0] regs[8];
    nine_t want_data[$];
    logic [1:0] want_stat[$];
    int errors;

    function new();
      for (int i = 0; i < 9; i++) mat[i] = (i % 4 == 0) ? 64'sd65536 : 0;
      regs = '{16'd0, 16'd0, 16'd1, 16'd1, 16'd0, 16'd0, 16'd2, 16'd16};
      built = 0;
      colin = 0;
      errors = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [15:0] d);
      regs[idx] = (idx == CFG_ORDER) ? {14'd0, d[1:0]} : d;
      built = 0;
    endfunction

    function longint round_frac(longint x);
      bit [63:0] mag;
      mag = (x < 0) ? -x : x;
      mag = (mag + 64'd32768) >> MATRIX_FRAC_BITS;
      return (x < 0) ? -longint'(mag) : longint'(mag);
    endfunction

    function bit [63:0] sqrt_floor(bit [63:0] x);
      bit [63:0] r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
        if (x >= r + b) begin
          x = x - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    function void unit_vec(input longint v[3], output longint q[3]);
      bit [63:0] w[3], m, s, r, c;
      m = 0;
      s = 0;
      for (int i = 0; i < 3; i++) begin
        w[i] = (v[i] < 0) ? -v[i] : v[i];
        if (w[i] > m) m = w[i];
      end
      while (m < (64'd1 << 30)) begin
        m = m << 1;
        for (int i = 0; i < 3; i++) w[i] = w[i] << 1;
      end
      for (int i = 0; i < 3; i++) s += w[i] * w[i];
      r = sqrt_floor(s);
      for (int i = 0; i < 3; i++) begin
        c = ((w[i] << MATRIX_FRAC_BITS) + (r >> 1)) / r;
        if (c > 64'd65536) c = 64'd65536;
        q[i] = (v[i] < 0) ? -longint'(c) : longint'(c);
      end
    endfunction

    function void build_frame();
      longint a1[3], a2[3], u[3], a[3], b[3], c[3], rows[3][3];
      bit [63:0] big_a, big_u, lim, thr, l64;
      big_a = 0;
      big_u = 0;
      for (int i = 0; i < 3; i++) begin
        a1[i] = longint'($signed(regs[i]));
        a2[i] = longint'($signed(regs[3 + i]));
      end
      u[0] = a1[1] * a2[2] - a1[2] * a2[1];
      u[1] = a1[2] * a2[0] - a1[0] * a2[2];
      u[2] = a1[0] * a2[1] - a1[1] * a2[0];
      for (int i = 0; i < 3; i++) begin
        big_a += a1[i] * a1[i];
        big_u += u[i] * u[i];
      end
      l64 = regs[CFG_LIMIT];
      lim = l64 * l64 * big_a;
      thr = (lim >> 32) + ((lim[31:0] != 0) ? 64'd1 : 64'd0);
      built = 1;
      // A vanishing perpendicular part falls back to the identity frame.
      if (big_u == 0 || big_u < thr) begin
        colin = 1;
        for (int i = 0; i < 9; i++) mat[i] = (i % 4 == 0) ? 64'sd65536 : 0;
        return;
      end
      colin = 0;
      unit_vec(a1, a);
      unit_vec(u, c);
      b[0] = round_frac(c[1] * a[2] - c[2] * a[1]);
      b[1] = round_frac(c[2] * a[0] - c[0] * a[2]);
      b[2] = round_frac(c[0] * a[1] - c[1] * a[0]);
      case (regs[CFG_ORDER][1:0])
        ORD_ABC: begin rows[0] = a; rows[1] = b; rows[2] = c; end
        ORD_CAB: begin rows[0] = c; rows[1] = a; rows[2] = b; end
        default: begin rows[0] = b; rows[1] = c; rows[2] = a; end
      endcase
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++) mat[i * 3 + j] = rows[i][j];
    endfunction

    function longint clip(longint x, inout bit flag);
      if (x > 64'sd2147483647) begin flag = 1; return 64'sd2147483647; end
      if (x < -64'sd2147483648) begin flag = 1; return -64'sd2147483648; end
      return x;
    endfunction

    function void note_input(logic [1:0] op, nine_t d);
      longint t[9], p[9], acc;
      nine_t res;
      bit sat;
      sat = 0;
      res = '0;
      if (!built) build_frame();
      for (int i = 0; i < 9; i++) t[i] = longint'($signed(d[i]));
      if (op == OP_FWD || op == OP_INV) begin
        for (int i = 0; i < 3; i++) begin
          acc = 0;
          for (int k = 0; k < 3; k++)
            acc += ((op == OP_FWD) ? mat[k * 3 + i] : mat[i * 3 + k]) * t[k];
          res[i] = clip(round_frac(acc), sat);
        end
      end else begin
        for (int k = 0; k < 3; k++)
          for (int j = 0; j < 3; j++) begin
            acc = 0;
            for (int i = 0; i < 3; i++) acc += t[k * 3 + i] * mat[i * 3 + j];
            p[k * 3 + j] = round_frac(acc);
          end
        for (int i = 0; i < 3; i++)
          for (int j = 0; j < 3; j++) begin
            acc = 0;
            for (int k = 0; k < 3; k++) acc += mat[k * 3 + i] * p[k * 3 + j];
            res[i * 3 + j] = clip(round_frac(acc), sat);
          end
      end
      want_data.push_back(res);
      want_stat.push_back(colin ? ST_COLINEAR : (sat ? ST_SAT : ST_OK));
    endfunction

    function void check_result(nine_t got, logic [1:0] st);
      nine_t exp_d;
      logic [1:0] exp_s;
      if (want_data.size() == 0) begin
        $error("result transfer with nothing outstanding");
        errors++;
        return;
      end
      exp_d = want_data.pop_front();
      exp_s = want_stat.pop_front();
      for (int i = 0; i < 9; i++)
        if (got[i] !== exp_d[i]) begin
          $error("out_%0d: expected %0d, got %0d", i, $signed(exp_d[i]), $signed(got[i]));
          errors++;
        end
      if (st !== exp_s) begin
        $error("status: expected %0d, got %0d", exp_s, st);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [15:0] cfg_data;
  logic in_valid, in_ready, out_valid, out_ready;
  logic [1:0] op, status;
  nine_t in_data, out_data;

  frame_scoreboard sb = new();
  int cycles = 0;
  int burst_left = 0;
  int rx_left = 0;
  int rx_mode = 0;

  always #5 clk_i = ~clk_i;

  axes_frame_rotation i_dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_we_i(cfg_we), .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .op_i(op),
    .in_0_i(in_data[0]), .in_1_i(in_data[1]), .in_2_i(in_data[2]),
    .in_3_i(in_data[3]), .in_4_i(in_data[4]), .in_5_i(in_data[5]),
    .in_6_i(in_data[6]), .in_7_i(in_data[7]), .in_8_i(in_data[8]),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .out_0_o(out_data[0]), .out_1_o(out_data[1]), .out_2_o(out_data[2]),
    .out_3_o(out_data[3]), .out_4_o(out_data[4]), .out_5_o(out_data[5]),
    .out_6_o(out_data[6]), .out_7_o(out_data[7]), .out_8_o(out_data[8]),
    .status_o(status)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Receiver: checks each transfer and stalls in modes of random length.
  always @(posedge clk_i) begin
    if (out_valid && out_ready) sb.check_result(out_data, status);
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_left = $urandom_range(1, 40);
    end
    rx_left--;
    case (rx_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 3) != 0);
      2: out_ready <= 1'($urandom_range(0, 1));
      default: out_ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 5))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'($signed($urandom_range(0, 2097152)) - 1048576);
      3: return 32'($signed($urandom_range(0, 1024)) - 512) << 16;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] pick_axis();
    if ($urandom_range(0, 2) == 0) return 16'($signed($urandom_range(0, 16)) - 8);
    return 16'($urandom);
  endfunction

  // Called at a clock edge; returns at the edge where the next item may be driven.
  task automatic send(input logic [1:0] o, input nine_t d);
    in_valid <= 1'b1;
    op <= o;
    in_data <= d;
    do @(posedge clk_i); while (!in_ready);
    sb.note_input(o, d);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
    end
  endtask

  task automatic send_random(input int n);
    nine_t d;
    for (int k = 0; k < n; k++) begin
      for (int i = 0; i < 9; i++) d[i] = pick_value();
      send(2'($urandom_range(0, 3)), d);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.want_data.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic load_frame(input logic [15:0] r[8]);
    drain();
    for (int i = 0; i < 8; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= 3'(i);
      cfg_data <= r[i];
      sb.write_reg(3'(i), r[i]);
      @(posedge clk_i);
    end
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin
    logic [15:0] r[8];
    nine_t d;
    rst_ni = 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= CFG_FIRST_X;
    cfg_data <= '0;
    in_valid <= 1'b0;
    op <= OP_FWD;
    in_data <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset frame: field extremes under every operation code.
    for (int o = 0; o < 4; o++) begin
      d = {9{32'h7fff_ffff}};
      send(2'(o), d);
      d = {9{32'h8000_0000}};
      send(2'(o), d);
      d = '0;
      send(2'(o), d);
      for (int i = 0; i < 9; i++) d[i] = (i % 2) ? 32'h8000_0000 : 32'h7fff_ffff;
      send(2'(o), d);
      for (int i = 0; i < 9; i++) d[i] = 32'(i + 1) << 16;
      send(2'(o), d);
    end
    send_random(80);

    for (int ph = 0; ph < 13; ph++) begin
      for (int i = 0; i < 6; i++) r[i] = pick_axis();
      r[CFG_ORDER] = 16'($urandom_range(0, 3));
      r[CFG_LIMIT] = ($urandom_range(0, 1)) ? 16'($urandom_range(0, 64)) : 16'($urandom);
      case (ph)
        0: r = '{16'h7fff, 16'h8000, 16'h0000, 16'h8000, 16'h8000, 16'h7fff,
                 ORD_ABC, 16'd0};
        1: r = '{16'd3, 16'd5, -16'sd7, 16'd6, 16'd10, -16'sd14, ORD_CAB, 16'd16};
        2: begin r[0] = '0; r[1] = '0; r[2] = '0; r[CFG_ORDER] = ORD_BCA; end
        3: begin r[CFG_ORDER] = ORD_SPARE; r[CFG_LIMIT] = 16'hffff; end
        4: r = '{16'd1000, 16'd0, 16'd0, 16'd1000, 16'd1, 16'd0, ORD_ABC, 16'hffff};
        5: r = '{16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h8000, 16'h8000,
                 ORD_CAB, 16'd1};
        default: ;
      endcase
      load_frame(r);
      send_random(ph < 6 ? 70 : 100);
    end

    drain();
    repeat (20) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
